[sv/snt_pkg.sv]
// ----------------------------------------------------------------------------
// snt_pkg
// shared opcodes, the config width and width and depth helpers for the neighborhood table
// ----------------------------------------------------------------------------
package snt_pkg;

  localparam int LIMIT_W = 4;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // signed width of one offset coordinate
  function automatic int coord_width(input int radius);
    return $clog2(radius + 1) + 1;
  endfunction

  // width of a squared length, up to three times radius squared
  function automatic int dist_width(input int radius);
    return $clog2(3 * radius * radius + 1);
  endfunction

  // number of offsets in the full cube
  function automatic int table_depth(input int radius);
    return (2 * radius + 1) * (2 * radius + 1) * (2 * radius + 1);
  endfunction

endpackage

[sv/snt_ram.sv]
// ----------------------------------------------------------------------------
// snt_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module snt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/spherical_neighborhood_table_unit.sv]
// ----------------------------------------------------------------------------
// spherical_neighborhood_table_unit
// table of integer 3d offsets inside a sphere, centre first, then by length
// ----------------------------------------------------------------------------
// read: accepted when start is high and busy low, done strobes the next cycle;
//   reads can be accepted back to back, one per cycle
// build: walks the (2R+1)^3 cube, then one sort pass per position i (i = 1..n-2),
//   each streaming entries i..n-1 through the single ram read port
// reset: synchronous, clears the fsm, the count and the table-ready flag, the limit
//   returns to 1, the ram is kept; the receiver cannot stall, each done is a transfer
module spherical_neighborhood_table_unit
  import snt_pkg::*;
#(
  parameter int MAX_RADIUS = 3
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     start,
  output logic                                     busy,
  input  logic                                     opcode,
  input  logic [$clog2(table_depth(MAX_RADIUS))-1:0] entry_index,
  input  logic                                     cfg_write_en,
  input  logic [LIMIT_W-1:0]                       cfg_write_data,
  output logic                                     done,
  output logic signed [coord_width(MAX_RADIUS)-1:0] offset_x,
  output logic signed [coord_width(MAX_RADIUS)-1:0] offset_y,
  output logic signed [coord_width(MAX_RADIUS)-1:0] offset_z,
  output logic [dist_width(MAX_RADIUS)-1:0]        distance_sq,
  output logic [$clog2(table_depth(MAX_RADIUS)+1)-1:0] entry_count,
  output logic                                     index_invalid
);

  localparam int COORD_W = coord_width(MAX_RADIUS);
  localparam int DIST_W  = dist_width(MAX_RADIUS);
  localparam int DEPTH   = table_depth(MAX_RADIUS);
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 3 * COORD_W + DIST_W;
  localparam int CMP_W   = (DIST_W > LIMIT_W) ? DIST_W : LIMIT_W;
  localparam int SQ_W    = 2 * COORD_W;

  localparam logic signed [COORD_W-1:0] C_MAX = COORD_W'(MAX_RADIUS);
  localparam logic signed [COORD_W-1:0] C_MIN = -C_MAX;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENUM,    // walk the cube, write kept offsets
    S_SCAN,    // one selection pass: stream entries i..n-1 through the compare
    S_SWAP_A,  // write the smallest entry to position i
    S_SWAP_B   // write the old entry i to where the smallest came from
  } state_t;

  state_t state;

  // configuration
  logic [LIMIT_W-1:0] sq_limit;

  // table status
  logic [CNT_W-1:0] stored_count;
  logic             table_ready;

  // enumeration counters
  logic signed [COORD_W-1:0] dx, dy, dz;
  logic [CNT_W-1:0]          wr_pos;

  // sort sequencer
  logic [CNT_W-1:0]  pass_i;
  logic [CNT_W-1:0]  scan_j;
  logic              pend;
  logic [ADDR_W-1:0] pend_idx;
  logic [ADDR_W-1:0] best_idx;
  logic [WORD_W-1:0] best_word;
  logic [WORD_W-1:0] head_word;

  // result flags
  logic out_read;
  logic out_invalid;

  // ram port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // squared length of the current cube offset
  logic signed [SQ_W-1:0] sq_x, sq_y, sq_z;
  logic [DIST_W-1:0]      cur_dist;
  logic                   keep;
  logic                   is_centre;
  logic                   cube_last;
  logic [CNT_W-1:0]       wr_pos_next;

  assign sq_x = SQ_W'(dx) * SQ_W'(dx);
  assign sq_y = SQ_W'(dy) * SQ_W'(dy);
  assign sq_z = SQ_W'(dz) * SQ_W'(dz);
  assign cur_dist = DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
  assign keep = CMP_W'(cur_dist) <= CMP_W'(sq_limit);
  assign is_centre = (dx == '0) && (dy == '0) && (dz == '0);
  assign cube_last = (dx == C_MAX) && (dy == C_MAX) && (dz == C_MAX);
  // the centre goes straight to position 0, which is the effect of rotating it
  // to the front; all other kept offsets fill from position 1 in cube order
  assign wr_pos_next = (keep && !is_centre) ? wr_pos + 1'b1 : wr_pos;

  // compare unit: distance field sits in the low bits of a word
  logic rd_smaller;
  assign rd_smaller = ram_rdata[DIST_W-1:0] < best_word[DIST_W-1:0];

  logic read_bad;
  assign read_bad = !table_ready || (CNT_W'(entry_index) >= stored_count);

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = entry_index;
    case (state)
      S_ENUM: begin
        ram_we    = keep;
        ram_waddr = is_centre ? '0 : wr_pos[ADDR_W-1:0];
        ram_wdata = {dx, dy, dz, cur_dist};
      end
      S_SCAN: begin
        ram_raddr = scan_j[ADDR_W-1:0];
      end
      S_SWAP_A: begin
        ram_we    = 1'b1;
        ram_waddr = pass_i[ADDR_W-1:0];
        ram_wdata = best_word;
      end
      S_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = best_idx;
        ram_wdata = head_word;
      end
      default: begin
        ram_raddr = entry_index;
      end
    endcase
  end

  snt_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sequencer, status and result flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sq_limit     <= LIMIT_W'(1);
      stored_count <= '0;
      table_ready  <= 1'b0;
      done         <= 1'b0;
      out_read     <= 1'b0;
      out_invalid  <= 1'b0;
      pend         <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_write_en) begin
        sq_limit <= cfg_write_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (opcode == OP_BUILD) begin
              dx     <= C_MIN;
              dy     <= C_MIN;
              dz     <= C_MIN;
              wr_pos <= CNT_W'(1);
              state  <= S_ENUM;
            end else begin
              done        <= 1'b1;
              out_read    <= 1'b1;
              out_invalid <= read_bad;
            end
          end
        end
        S_ENUM: begin
          wr_pos <= wr_pos_next;
          if (dx == C_MAX) begin
            dx <= C_MIN;
            if (dy == C_MAX) begin
              dy <= C_MIN;
              dz <= dz + 1'b1;
            end else begin
              dy <= dy + 1'b1;
            end
          end else begin
            dx <= dx + 1'b1;
          end
          if (cube_last) begin
            stored_count <= wr_pos_next;
            pass_i       <= CNT_W'(1);
            scan_j       <= CNT_W'(1);
            pend         <= 1'b0;
            if (CNT_W'(2) < wr_pos_next) begin
              state <= S_SCAN;
            end else begin
              table_ready <= 1'b1;
              done        <= 1'b1;
              out_read    <= 1'b0;
              out_invalid <= 1'b0;
              state       <= S_IDLE;
            end
          end
        end
        S_SCAN: begin
          // data read last cycle arrives now
          if (pend) begin
            if (pend_idx == pass_i[ADDR_W-1:0]) begin
              head_word <= ram_rdata;
              best_word <= ram_rdata;
              best_idx  <= pend_idx;
            end else if (rd_smaller) begin
              best_word <= ram_rdata;
              best_idx  <= pend_idx;
            end
          end
          if (scan_j < stored_count) begin
            pend     <= 1'b1;
            pend_idx <= scan_j[ADDR_W-1:0];
            scan_j   <= scan_j + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= S_SWAP_A;
            end
          end
        end
        S_SWAP_A: begin
          state <= S_SWAP_B;
        end
        S_SWAP_B: begin
          pass_i <= pass_i + 1'b1;
          scan_j <= pass_i + 1'b1;
          if (pass_i + CNT_W'(2) < stored_count) begin
            state <= S_SCAN;
          end else begin
            table_ready <= 1'b1;
            done        <= 1'b1;
            out_read    <= 1'b0;
            out_invalid <= 1'b0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  // results: ram data only on a good read, zeros on a build or a bad read
  logic show_entry;
  assign show_entry = out_read && !out_invalid;

  assign offset_x      = show_entry ? ram_rdata[WORD_W-1 -: COORD_W] : '0;
  assign offset_y      = show_entry ? ram_rdata[WORD_W-COORD_W-1 -: COORD_W] : '0;
  assign offset_z      = show_entry ? ram_rdata[DIST_W+COORD_W-1 -: COORD_W] : '0;
  assign distance_sq   = show_entry ? ram_rdata[DIST_W-1:0] : '0;
  assign entry_count   = stored_count;
  assign index_invalid = out_read && out_invalid;

endmodule

[sv/snt_checker.sv]
// ----------------------------------------------------------------------------
// snt_checker
// port-level checks on the neighborhood table, bound to the top level
// ----------------------------------------------------------------------------
module snt_checker
  import snt_pkg::*;
#(
  parameter int MAX_RADIUS = 3
) (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          start,
  input logic                                          busy,
  input logic                                          opcode,
  input logic [$clog2(table_depth(MAX_RADIUS))-1:0]    entry_index,
  input logic                                          cfg_write_en,
  input logic [LIMIT_W-1:0]                            cfg_write_data,
  input logic                                          done,
  input logic signed [coord_width(MAX_RADIUS)-1:0]     offset_x,
  input logic signed [coord_width(MAX_RADIUS)-1:0]     offset_y,
  input logic signed [coord_width(MAX_RADIUS)-1:0]     offset_z,
  input logic [dist_width(MAX_RADIUS)-1:0]             distance_sq,
  input logic [$clog2(table_depth(MAX_RADIUS)+1)-1:0]  entry_count,
  input logic                                          index_invalid
);

  // a read transfer is answered in the very next cycle
  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_READ) |=> done)
    else $error("read not answered in one cycle");

  // a build holds off new commands while it runs
  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == OP_BUILD) |=> (busy && !done))
    else $error("build did not go busy");

  // a result never appears while a build is still running
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result during build");

  // a rejected read carries no entry
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && index_invalid) |->
      (offset_x == '0 && offset_y == '0 && offset_z == '0 && distance_sq == '0))
    else $error("invalid read returned data");

  // a good read or a finished build always sees a non-empty table
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && !index_invalid) |-> (entry_count != '0))
    else $error("empty table on a valid result");

endmodule

bind spherical_neighborhood_table_unit snt_checker #(
  .MAX_RADIUS(MAX_RADIUS)
) u_snt_checker (.*);
